// ===== sv/mrc_pkg.sv =====
package mrc_pkg;

	// Field widths
	localparam int POS_W    = 31;
	localparam int CNT_W    = 24;
	localparam int MARGIN_W = 16;
	localparam int CHROM_W  = 64;
	localparam int CLEN_W   = 5;
	localparam int IDX_W    = 3;

	// Longest chromosome name held in the name registers
	localparam int CHROM_MAX_BYTES = 16;

	// Default queue depths
	localparam int LINE_QUEUE_DEPTH_DEF   = 4;
	localparam int RESULT_QUEUE_DEPTH_DEF = 2;

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Result status codes
	typedef enum logic [2:0] {
		ST_EQUAL  = 3'd0,
		ST_BEFORE = 3'd1,
		ST_AFTER  = 3'd2,
		ST_REJECT = 3'd3,
		ST_OTHER  = 3'd4
	} status_t;

	// Strand token codes
	typedef enum logic [1:0] {
		STRAND_PLUS  = 2'd0,
		STRAND_MINUS = 2'd1,
		STRAND_OTHER = 2'd2
	} strand_t;

	// Strand filter modes; the fourth code passes every strand
	typedef enum logic [1:0] {
		SM_ANY   = 2'd0,
		SM_PLUS  = 2'd1,
		SM_MINUS = 2'd2
	} strand_mode_t;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		CFG_MIN_METH     = 3'd0,
		CFG_MIN_COVER    = 3'd1,
		CFG_RATIO_MARGIN = 3'd2,
		CFG_STRAND_MODE  = 3'd3,
		CFG_CHROM_LOW    = 3'd4,
		CFG_CHROM_HIGH   = 3'd5,
		CFG_CHROM_LENGTH = 3'd6
	} cfg_idx_t;

	// Parsed line handed from the tokeniser to the classifier
	typedef struct packed {
		logic              other_chrom;
		logic [1:0]        strand_first;
		logic [1:0]        strand_seen;
		logic [POS_W-1:0]  site_position;
		logic [CNT_W-1:0]  meth_count;
		logic [CNT_W-1:0]  cover_count;
		logic [POS_W-1:0]  ref_position;
	} line_rec_t;

	// Finished result word
	typedef struct packed {
		status_t           status;
		logic [POS_W-1:0]  site_position;
		logic [1:0]        strand_code;
		logic [CNT_W-1:0]  meth_count;
		logic [CNT_W-1:0]  cover_count;
	} result_rec_t;

	// Filter settings seen by the classifier
	typedef struct packed {
		logic [CNT_W-1:0]    min_meth;
		logic [CNT_W-1:0]    min_cover;
		logic [MARGIN_W-1:0] ratio_margin;
		logic [1:0]          strand_mode;
	} filter_cfg_t;

endpackage

// ===== sv/mrc_queue.sv =====
module mrc_queue import mrc_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = LINE_QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/mrc_front.sv =====
module mrc_front import mrc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         text_byte,
	input  logic               line_end,
	input  logic [POS_W-1:0]   ref_position,
	input  logic [CHROM_W-1:0] chrom_word_low,
	input  logic [CHROM_W-1:0] chrom_word_high,
	input  logic [CLEN_W-1:0]  chrom_length,
	output logic               line_push,
	output line_rec_t          line_rec
);

	localparam logic [2:0] FLD_CHROM  = 3'd1;
	localparam logic [2:0] FLD_POS    = 3'd2;
	localparam logic [2:0] FLD_STRAND = 3'd3;
	localparam logic [2:0] FLD_METH   = 3'd5;
	localparam logic [2:0] FLD_COVER  = 3'd6;
	localparam logic [2:0] FLD_LAST   = 3'd7;
	localparam logic [4:0] TLEN_MAX   = 5'd31;

	// Multiply by ten, add a digit, clamp at cap
	function automatic logic [POS_W-1:0] add_digit(input logic [POS_W-1:0] acc,
			input logic [3:0] d, input logic [POS_W-1:0] cap);
		logic [POS_W+3:0] v;
		v = (POS_W+4)'({acc, 3'b000}) + (POS_W+4)'({acc, 1'b0}) + (POS_W+4)'(d);
		return (v > (POS_W+4)'(cap)) ? cap : v[POS_W-1:0];
	endfunction

	logic [2:0]       field_q, field_n;
	logic             inside_q, inside_n;
	logic [4:0]       tlen_q, tlen_n;
	logic             mis_q, mis_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [1:0]       seen_q, seen_n;
	logic [1:0]       first_q, first_n;
	logic [CNT_W-1:0] meth_q, meth_n;
	logic [CNT_W-1:0] cover_q, cover_n;
	logic             stopped_q, stopped_n;

	logic [127:0]      name_bytes;
	logic [CLEN_W-1:0] name_len;
	logic              is_delim;
	logic              is_digit;
	logic [3:0]        digit;
	logic [4:0]        k;
	logic [1:0]        strand_tok;
	logic              final_mis;

	assign name_bytes = {chrom_word_high, chrom_word_low};
	assign name_len   = (chrom_length > CLEN_W'(CHROM_MAX_BYTES)) ?
		CLEN_W'(CHROM_MAX_BYTES) : chrom_length;
	assign is_delim   = (text_byte == 8'h20) || (text_byte == 8'h09) || (text_byte == 8'h0A);
	assign is_digit   = (text_byte >= 8'h30) && (text_byte <= 8'h39);
	assign digit      = text_byte[3:0];
	assign strand_tok = (text_byte == 8'h2B) ? STRAND_PLUS :
		(text_byte == 8'h2D) ? STRAND_MINUS : STRAND_OTHER;
	assign k          = inside_q ? tlen_q : 5'd0;

	// Tokeniser: next line state for the current byte
	always_comb begin
		field_n   = field_q;
		inside_n  = inside_q;
		tlen_n    = tlen_q;
		mis_n     = mis_q;
		pos_n     = pos_q;
		seen_n    = seen_q;
		first_n   = first_q;
		meth_n    = meth_q;
		cover_n   = cover_q;
		stopped_n = stopped_q;
		if (is_delim) begin
			if (inside_q) begin
				if (field_q == FLD_CHROM && tlen_q != name_len) begin
					mis_n = 1'b1;
				end
				inside_n = 1'b0;
			end
		end else begin
			if (!inside_q) begin
				stopped_n = 1'b0;
				if (field_q < FLD_LAST) begin
					field_n = field_q + 1'b1;
				end
			end
			inside_n = 1'b1;
			if (!is_digit) begin
				stopped_n = 1'b1;
			end
			case (field_n)
				FLD_CHROM: begin
					if (k >= name_len || name_bytes[{k[3:0], 3'b000} +: 8] != text_byte) begin
						mis_n = 1'b1;
					end
				end
				FLD_POS: begin
					if (!stopped_n) begin
						pos_n = add_digit(pos_q, digit, POS_MAX);
					end
				end
				FLD_STRAND: begin
					if (k == 5'd0) begin
						first_n = strand_tok;
						seen_n  = strand_tok;
					end else begin
						seen_n  = STRAND_OTHER;
					end
				end
				FLD_METH: begin
					if (!stopped_n) begin
						meth_n = CNT_W'(add_digit(POS_W'(meth_q), digit, POS_W'(CNT_MAX)));
					end
				end
				FLD_COVER: begin
					if (!stopped_n) begin
						cover_n = CNT_W'(add_digit(POS_W'(cover_q), digit, POS_W'(CNT_MAX)));
					end
				end
				default: ;
			endcase
			tlen_n = (k < TLEN_MAX) ? k + 1'b1 : k;
		end
	end

	// Line end closes an open name token
	assign final_mis = mis_n || (inside_n && field_n == FLD_CHROM && tlen_n != name_len);

	assign line_push = accept && line_end;

	always_comb begin
		line_rec.other_chrom   = (field_n == 3'd0) ? (name_len != '0) : final_mis;
		line_rec.strand_first  = first_n;
		line_rec.strand_seen   = seen_n;
		line_rec.site_position = pos_n;
		line_rec.meth_count    = meth_n;
		line_rec.cover_count   = cover_n;
		line_rec.ref_position  = ref_position;
	end

	// Line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q   <= '0;
			inside_q  <= 1'b0;
			tlen_q    <= '0;
			mis_q     <= 1'b0;
			pos_q     <= '0;
			seen_q    <= STRAND_OTHER;
			first_q   <= STRAND_OTHER;
			meth_q    <= '0;
			cover_q   <= '0;
			stopped_q <= 1'b0;
		end else if (line_push) begin
			field_q   <= '0;
			inside_q  <= 1'b0;
			tlen_q    <= '0;
			mis_q     <= 1'b0;
			pos_q     <= '0;
			seen_q    <= STRAND_OTHER;
			first_q   <= STRAND_OTHER;
			meth_q    <= '0;
			cover_q   <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			field_q   <= field_n;
			inside_q  <= inside_n;
			tlen_q    <= tlen_n;
			mis_q     <= mis_n;
			pos_q     <= pos_n;
			seen_q    <= seen_n;
			first_q   <= first_n;
			meth_q    <= meth_n;
			cover_q   <= cover_n;
			stopped_q <= stopped_n;
		end
	end

endmodule

// ===== sv/mrc_back.sv =====
module mrc_back import mrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  filter_cfg_t cfg,
	input  logic        line_empty,
	output logic        line_pop,
	input  line_rec_t   line_rec,
	input  logic        res_full,
	output logic        res_push,
	output result_rec_t res_rec
);

	localparam int LOW_W  = MARGIN_W + CNT_W;
	localparam int HIGH_W = MARGIN_W + 1 + CNT_W;

	logic                  valid_s1;
	logic                  other_s1;
	logic                  early_rej_s1;
	status_t               pos_code_s1;
	logic [LOW_W-1:0]      low_s1;
	logic [HIGH_W-1:0]     high_s1;
	logic [POS_W-1:0]      pos_s1;
	logic [1:0]            strand_s1;
	logic [CNT_W-1:0]      meth_s1;
	logic [CNT_W-1:0]      cover_s1;

	logic [MARGIN_W:0]     inv_margin;
	logic [LOW_W-1:0]      low_prod;
	logic [HIGH_W-1:0]     high_prod;
	logic                  strand_fail;
	logic                  early_rej;
	status_t               pos_code;
	logic [LOW_W-1:0]      scaled;
	logic                  ratio_fail;
	logic                  advance;

	assign advance  = valid_s1 && !res_full;
	assign line_pop = !line_empty && (!valid_s1 || advance);
	assign res_push = advance;

	// Ratio bounds and simple filters on the queue head
	assign inv_margin = (MARGIN_W+1)'(1 << MARGIN_W) - (MARGIN_W+1)'(cfg.ratio_margin);
	assign low_prod   = LOW_W'(cfg.ratio_margin) * LOW_W'(line_rec.cover_count);
	assign high_prod  = HIGH_W'(inv_margin) * HIGH_W'(line_rec.cover_count);

	assign strand_fail =
		(cfg.strand_mode == SM_PLUS  && line_rec.strand_first != STRAND_PLUS) ||
		(cfg.strand_mode == SM_MINUS && line_rec.strand_first != STRAND_MINUS);
	assign early_rej = strand_fail ||
		(line_rec.meth_count < cfg.min_meth) ||
		(line_rec.cover_count < cfg.min_cover) ||
		(line_rec.cover_count == '0);
	assign pos_code = (line_rec.site_position < line_rec.ref_position) ? ST_BEFORE :
		(line_rec.site_position > line_rec.ref_position) ? ST_AFTER : ST_EQUAL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line_pop) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (line_pop) begin
			other_s1     <= line_rec.other_chrom;
			early_rej_s1 <= early_rej;
			pos_code_s1  <= pos_code;
			low_s1       <= low_prod;
			high_s1      <= high_prod;
			pos_s1       <= line_rec.site_position;
			strand_s1    <= line_rec.strand_seen;
			meth_s1      <= line_rec.meth_count;
			cover_s1     <= line_rec.cover_count;
		end
	end

	// Final verdict
	assign scaled     = {meth_s1, {MARGIN_W{1'b0}}};
	assign ratio_fail = (scaled < low_s1) || (HIGH_W'(scaled) > high_s1);

	always_comb begin
		if (other_s1) begin
			res_rec.status = ST_OTHER;
		end else if (early_rej_s1 || ratio_fail) begin
			res_rec.status = ST_REJECT;
		end else begin
			res_rec.status = pos_code_s1;
		end
		res_rec.site_position = pos_s1;
		res_rec.strand_code   = strand_s1;
		res_rec.meth_count    = meth_s1;
		res_rec.cover_count   = cover_s1;
	end

endmodule

// ===== sv/methylation_record_classifier.sv =====
// Methylation record classifier: streams one text byte of a whitespace separated
// record per cycle (push/full) and, one word per line, reports the line's status
// (same chromosome and position equal, before or after ref_position, rejected by
// the strand, count or ratio filters, or other chromosome) together with the
// parsed position, strand and counts (empty/pop). The tokeniser takes each byte
// as it is accepted; a finished line passes through the line queue, the classify
// stage (ratio multipliers) and the result queue before its result word is ready.
// full rises only while LINE_QUEUE_DEPTH finished lines wait to be classified.
// Write the filter registers only while no line is in flight.
module methylation_record_classifier import mrc_pkg::*; #(
	parameter int LINE_QUEUE_DEPTH   = LINE_QUEUE_DEPTH_DEF,
	parameter int RESULT_QUEUE_DEPTH = RESULT_QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               write_enable,
	input  logic [IDX_W-1:0]   reg_index,
	input  logic [CHROM_W-1:0] write_data,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         text_byte,
	input  logic               line_end,
	input  logic [POS_W-1:0]   ref_position,
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         status,
	output logic [POS_W-1:0]   site_position,
	output logic [1:0]         strand_code,
	output logic [CNT_W-1:0]   meth_count,
	output logic [CNT_W-1:0]   cover_count
);

	localparam int LINE_W   = $bits(line_rec_t);
	localparam int RESULT_W = $bits(result_rec_t);

	logic [CNT_W-1:0]    min_meth_q;
	logic [CNT_W-1:0]    min_cover_q;
	logic [MARGIN_W-1:0] ratio_margin_q;
	logic [1:0]          strand_mode_q;
	logic [CHROM_W-1:0]  chrom_low_q;
	logic [CHROM_W-1:0]  chrom_high_q;
	logic [CLEN_W-1:0]   chrom_length_q;

	logic        accept;
	logic        lq_push, lq_full, lq_pop, lq_empty;
	line_rec_t   lq_wdata, lq_rdata;
	logic        rq_push, rq_full;
	result_rec_t rq_wdata, rq_rdata;
	filter_cfg_t filt_cfg;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_meth_q     <= '0;
			min_cover_q    <= CNT_W'(1);
			ratio_margin_q <= '0;
			strand_mode_q  <= SM_ANY;
			chrom_low_q    <= '0;
			chrom_high_q   <= '0;
			chrom_length_q <= CLEN_W'(1);
		end else if (write_enable) begin
			unique case (cfg_idx_t'(reg_index))
				CFG_MIN_METH:     min_meth_q     <= write_data[CNT_W-1:0];
				CFG_MIN_COVER:    min_cover_q    <= write_data[CNT_W-1:0];
				CFG_RATIO_MARGIN: ratio_margin_q <= write_data[MARGIN_W-1:0];
				CFG_STRAND_MODE:  strand_mode_q  <= write_data[1:0];
				CFG_CHROM_LOW:    chrom_low_q    <= write_data;
				CFG_CHROM_HIGH:   chrom_high_q   <= write_data;
				CFG_CHROM_LENGTH: chrom_length_q <= write_data[CLEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign filt_cfg.min_meth     = min_meth_q;
	assign filt_cfg.min_cover    = min_cover_q;
	assign filt_cfg.ratio_margin = ratio_margin_q;
	assign filt_cfg.strand_mode  = strand_mode_q;

	assign full   = lq_full;
	assign accept = push && !lq_full;

	// Tokeniser
	mrc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.text_byte       (text_byte),
		.line_end        (line_end),
		.ref_position    (ref_position),
		.chrom_word_low  (chrom_low_q),
		.chrom_word_high (chrom_high_q),
		.chrom_length    (chrom_length_q),
		.line_push       (lq_push),
		.line_rec        (lq_wdata)
	);

	// Parsed lines waiting for the classifier
	mrc_queue #(
		.WIDTH (LINE_W),
		.DEPTH (LINE_QUEUE_DEPTH)
	) u_line_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (lq_push),
		.full   (lq_full),
		.wdata  (lq_wdata),
		.pop    (lq_pop),
		.empty  (lq_empty),
		.rdata  (lq_rdata)
	);

	// Classifier
	mrc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (filt_cfg),
		.line_empty (lq_empty),
		.line_pop   (lq_pop),
		.line_rec   (lq_rdata),
		.res_full   (rq_full),
		.res_push   (rq_push),
		.res_rec    (rq_wdata)
	);

	// Result words
	mrc_queue #(
		.WIDTH (RESULT_W),
		.DEPTH (RESULT_QUEUE_DEPTH)
	) u_result_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.full   (rq_full),
		.wdata  (rq_wdata),
		.pop    (pop),
		.empty  (empty),
		.rdata  (rq_rdata)
	);

	assign status        = rq_rdata.status;
	assign site_position = rq_rdata.site_position;
	assign strand_code   = rq_rdata.strand_code;
	assign meth_count    = rq_rdata.meth_count;
	assign cover_count   = rq_rdata.cover_count;

`ifndef SYNTHESIS
	// A finished line never meets a full line queue
	a_line_room: assert property (@(posedge clk) disable iff (!arst_n)
		lq_push |-> !lq_full)
		else $error("line queue overrun");

	// A finished line is waiting in the queue on the next cycle
	a_line_stored: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && line_end) |=> !lq_empty)
		else $error("finished line lost");

	// A passing record has nonzero coverage and a ratio of at most one
	a_pass_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == ST_EQUAL || status == ST_BEFORE || status == ST_AFTER))
		|-> (cover_count != '0 && meth_count <= cover_count))
		else $error("passing record breaks ratio bound");
`endif

endmodule

// ===== tb/sv/methylation_record_classifier_test.sv =====
module methylation_record_classifier_test;
	import mrc_pkg::*;

	typedef logic [7:0] octet_t;

	// Separator and sign characters of the record text
	localparam octet_t CH_SPACE = 8'h20;
	localparam octet_t CH_TAB   = 8'h09;
	localparam octet_t CH_NL    = 8'h0a;
	localparam octet_t CH_PLUS  = "+";
	localparam octet_t CH_MINUS = "-";
	localparam octet_t CH_ZERO  = "0";
	localparam octet_t CH_NINE  = "9";

	// Strand filter code outside the package enum: every strand passes
	localparam logic [1:0] SM_PASS_ALL = 2'd3;

	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned PHASE_BYTES  = 180;
	localparam int unsigned SETTLE_TICKS = 8;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               write_enable;
	logic [IDX_W-1:0]   reg_index;
	logic [CHROM_W-1:0] write_data;
	logic               push;
	logic               full;
	logic [7:0]         text_byte;
	logic               line_end;
	logic [POS_W-1:0]   ref_position;
	logic               empty;
	logic               pop;
	logic [2:0]         status;
	logic [POS_W-1:0]   site_position;
	logic [1:0]         strand_code;
	logic [CNT_W-1:0]   meth_count;
	logic [CNT_W-1:0]   cover_count;

	methylation_record_classifier uut (.*);

	// Line parser and filter model plus the queue of outcomes still owed
	class record_outcome_tracker;
		logic [CNT_W-1:0]    min_meth, min_cover;
		logic [MARGIN_W-1:0] margin;
		logic [1:0]          strand_mode;
		logic [CHROM_W-1:0]  name_low, name_high;
		logic [CLEN_W-1:0]   name_len;

		int unsigned      field_no, tok_len;
		bit               in_token, name_bad, digits_done;
		logic [POS_W-1:0] pos_acc;
		logic [CNT_W-1:0] meth_acc, cover_acc;
		strand_t          strand_seen, strand_first;

		result_rec_t pending_outcomes[$];
		int unsigned faults;

		function new();
			min_meth = '0;
			min_cover = 1;
			margin = '0;
			strand_mode = SM_ANY;
			name_low = '0;
			name_high = '0;
			name_len = 1;
			faults = 0;
			clear_line();
		endfunction

		function void clear_line();
			field_no = 0;
			in_token = 0;
			tok_len = 0;
			name_bad = 0;
			pos_acc = '0;
			strand_seen = STRAND_OTHER;
			strand_first = STRAND_OTHER;
			meth_acc = '0;
			cover_acc = '0;
			digits_done = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CHROM_W-1:0] v);
			case (idx)
				CFG_MIN_METH:     min_meth = v[CNT_W-1:0];
				CFG_MIN_COVER:    min_cover = v[CNT_W-1:0];
				CFG_RATIO_MARGIN: margin = v[MARGIN_W-1:0];
				CFG_STRAND_MODE:  strand_mode = v[1:0];
				CFG_CHROM_LOW:    name_low = v;
				CFG_CHROM_HIGH:   name_high = v;
				CFG_CHROM_LENGTH: name_len = v[CLEN_W-1:0];
				default: ;
			endcase
		endfunction

		// Lengths above the name store are clipped to it
		function int unsigned name_bytes();
			return (name_len > CHROM_MAX_BYTES) ? CHROM_MAX_BYTES : name_len;
		endfunction

		function octet_t name_byte(int unsigned k);
			return (k < 8) ? name_low[8*k +: 8] : name_high[8*(k-8) +: 8];
		endfunction

		function longint unsigned add_digit(longint unsigned acc, octet_t c,
				longint unsigned cap);
			longint unsigned v;
			v = acc * 10 + (c - CH_ZERO);
			return (v > cap) ? cap : v;
		endfunction

		function void close_token();
			if (field_no == 1 && tok_len != name_bytes())
				name_bad = 1;
			in_token = 0;
		endfunction

		// One text byte; on the line end byte the outcome is queued
		function void take_text_byte(octet_t c, logic last_byte, logic [POS_W-1:0] refpos);
			int unsigned     k;
			bit              other;
			status_t         verdict;
			longint unsigned scaled, low_bound, high_bound, mg, cv;
			result_rec_t     outcome;
			if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
				if (in_token)
					close_token();
			end else begin
				if (!in_token) begin
					in_token = 1;
					tok_len = 0;
					digits_done = 0;
					if (field_no < 7)
						field_no++;
				end
				k = tok_len;
				if (c < CH_ZERO || c > CH_NINE)
					digits_done = 1;
				case (field_no)
					1: if (k >= name_bytes() || name_byte(k) != c)
						name_bad = 1;
					2: if (!digits_done)
						pos_acc = POS_W'(add_digit(pos_acc, c, POS_MAX));
					3: if (k == 0) begin
						if (c == CH_PLUS)
							strand_first = STRAND_PLUS;
						else if (c == CH_MINUS)
							strand_first = STRAND_MINUS;
						else
							strand_first = STRAND_OTHER;
						strand_seen = strand_first;
					end else begin
						strand_seen = STRAND_OTHER;
					end
					5: if (!digits_done)
						meth_acc = CNT_W'(add_digit(meth_acc, c, CNT_MAX));
					6: if (!digits_done)
						cover_acc = CNT_W'(add_digit(cover_acc, c, CNT_MAX));
					default: ;
				endcase
				if (tok_len < 31)
					tok_len++;
			end
			if (!last_byte)
				return;
			if (in_token)
				close_token();

			// Chromosome first, then strand, counts, ratio, then position
			other = (field_no == 0) ? (name_bytes() != 0) : name_bad;
			mg = margin;
			cv = cover_acc;
			scaled = meth_acc;
			scaled = scaled << 16;
			low_bound = mg * cv;
			high_bound = (65536 - mg) * cv;
			if (other)
				verdict = ST_OTHER;
			else if ((strand_mode == SM_PLUS && strand_first != STRAND_PLUS) ||
					(strand_mode == SM_MINUS && strand_first != STRAND_MINUS))
				verdict = ST_REJECT;
			else if (meth_acc < min_meth || cover_acc < min_cover || cover_acc == 0)
				verdict = ST_REJECT;
			else if (scaled < low_bound || scaled > high_bound)
				verdict = ST_REJECT;
			else if (pos_acc < refpos)
				verdict = ST_BEFORE;
			else if (pos_acc > refpos)
				verdict = ST_AFTER;
			else
				verdict = ST_EQUAL;
			outcome.status = verdict;
			outcome.site_position = pos_acc;
			outcome.strand_code = strand_seen;
			outcome.meth_count = meth_acc;
			outcome.cover_count = cover_acc;
			pending_outcomes.push_back(outcome);
			clear_line();
		endfunction

		function void match_outcome(result_rec_t got);
			result_rec_t want;
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result word, status %0d position %0d",
					$time, got.status, got.site_position);
				faults++;
				return;
			end
			want = pending_outcomes.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status,
					got.status);
				faults++;
			end
			if (got.site_position !== want.site_position) begin
				$display("%0t: site_position expected %0d actual %0d", $time,
					want.site_position, got.site_position);
				faults++;
			end
			if (got.strand_code !== want.strand_code) begin
				$display("%0t: strand_code expected %0d actual %0d", $time,
					want.strand_code, got.strand_code);
				faults++;
			end
			if (got.meth_count !== want.meth_count) begin
				$display("%0t: meth_count expected %0d actual %0d", $time,
					want.meth_count, got.meth_count);
				faults++;
			end
			if (got.cover_count !== want.cover_count) begin
				$display("%0t: cover_count expected %0d actual %0d", $time,
					want.cover_count, got.cover_count);
				faults++;
			end
		endfunction
	endclass

	record_outcome_tracker tracker;
	octet_t                line_q[$];
	int unsigned           send_gap_max = 13;
	int unsigned           take_gap_max = 13;
	int unsigned           bytes_sent = 0;
	int unsigned           cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("methylation_record_classifier verification failed");
			$finish;
		end
	end

	function automatic bit is_blank(octet_t c);
		return c == CH_SPACE || c == CH_TAB || c == CH_NL;
	endfunction

	function automatic octet_t pick_delim();
		case ($urandom_range(0, 2))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			default: return CH_NL;
		endcase
	endfunction

	function automatic int unsigned pick_gap();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 3;
			default: return 13;
		endcase
	endfunction

	// Eight name characters, never a separator
	function automatic logic [CHROM_W-1:0] random_name_word();
		logic [CHROM_W-1:0] w;
		octet_t             c;
		int                 k;
		for (k = 0; k < 8; k++) begin
			c = octet_t'($urandom_range(0, 255));
			if (is_blank(c))
				c = "Q";
			w[8*k +: 8] = c;
		end
		return w;
	endfunction

	function automatic longint unsigned pick_value(input longint unsigned cap);
		case ($urandom_range(0, 6))
			0:       return $urandom_range(0, 30);
			1:       return {$urandom, $urandom} % (cap + 2);
			2:       return cap;
			3:       return cap + 1;
			4:       return 64'd99999999999;
			default: return $urandom_range(0, 1000);
		endcase
	endfunction

	// Decimal text for v, sometimes with a sign, a non-digit tail or leading zeros
	function automatic string spell_number(input longint unsigned v,
			input longint unsigned cap, output longint unsigned parsed);
		string txt;
		txt = $sformatf("%0d", v);
		parsed = (v > cap) ? cap : v;
		case ($urandom_range(0, 11))
			0: begin
				txt = {"-", txt};
				parsed = 0;
			end
			1:       txt = {txt, "x9"};
			2:       txt = {"00", txt};
			default: ;
		endcase
		return txt;
	endfunction

	task automatic add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endtask

	// Offer one text byte and hold it until the block takes it
	task automatic send_word(input octet_t c, input logic lst, input logic [POS_W-1:0] rp);
		int unsigned gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap != 0) begin
			push <= 1'b0;
			text_byte <= octet_t'($urandom);
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		text_byte <= c;
		line_end <= lst;
		ref_position <= rp;
		@(posedge clk);
		while (full)
			@(posedge clk);
		tracker.take_text_byte(c, lst, rp);
		bytes_sent++;
	endtask

	task automatic send_line(input logic [POS_W-1:0] rp);
		int unsigned i, n;
		logic [POS_W-1:0] rv;
		n = line_q.size();
		for (i = 0; i < n; i++) begin
			rv = (i == n - 1) ? rp : POS_W'($urandom);
			send_word(line_q[i], i == n - 1, rv);
		end
	endtask

	task automatic say_line(input string s, input logic [POS_W-1:0] rp);
		line_q.delete();
		add_text(s);
		send_line(rp);
	endtask

	// Stop sending and let every owed result word drain
	task automatic wait_for_outcomes();
		push <= 1'b0;
		while (tracker.pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CHROM_W-1:0] v);
		@(posedge clk);
		write_enable <= 1'b1;
		reg_index <= idx;
		write_data <= v;
		@(posedge clk);
		write_enable <= 1'b0;
		tracker.write_reg(idx, v);
	endtask

	// Write every register; unused upper bits carry noise
	task automatic set_filters(input logic [CNT_W-1:0] mm, input logic [CNT_W-1:0] mc,
			input logic [MARGIN_W-1:0] mg, input logic [1:0] sm,
			input logic [CHROM_W-1:0] lo, input logic [CHROM_W-1:0] hi,
			input logic [CLEN_W-1:0] len);
		logic [CHROM_W-1:0] noise;
		noise = {$urandom, $urandom};
		write_reg(CFG_MIN_METH, {noise[CHROM_W-1:CNT_W], mm});
		write_reg(CFG_MIN_COVER, {noise[CHROM_W-1:CNT_W], mc});
		write_reg(CFG_RATIO_MARGIN, {noise[CHROM_W-1:MARGIN_W], mg});
		write_reg(CFG_STRAND_MODE, {noise[CHROM_W-1:2], sm});
		write_reg(CFG_CHROM_LOW, lo);
		write_reg(CFG_CHROM_HIGH, hi);
		write_reg(CFG_CHROM_LENGTH, {noise[CHROM_W-1:CLEN_W], len});
	endtask

	// Build one random record line in line_q and choose its reference position
	task automatic make_record(output logic [POS_W-1:0] rp);
		int unsigned     kind, nf, f, k, n, head, nl;
		longint unsigned pos_p, cov_p, meth_p, mg, lo_m, hi_m, mv;
		string           pos_txt, strand_txt, meth_txt, cov_txt;
		octet_t          nb;
		line_q.delete();
		kind = $urandom_range(0, 99);
		rp = POS_W'($urandom);

		// raw noise
		if (kind < 8) begin
			n = $urandom_range(1, 20);
			for (k = 0; k < n; k++)
				line_q.push_back(octet_t'($urandom_range(0, 255)));
			return;
		end
		// separators only, no token at all
		if (kind < 11) begin
			n = $urandom_range(1, 3);
			for (k = 0; k < n; k++)
				line_q.push_back(pick_delim());
			return;
		end

		pos_txt = spell_number(pick_value(POS_MAX), POS_MAX, pos_p);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: strand_txt = "+";
			4, 5, 6:    strand_txt = "-";
			7:          strand_txt = ".";
			8:          strand_txt = "+-";
			default:    strand_txt = $sformatf("%c", $urandom_range(8'h21, 8'hff));
		endcase
		cov_txt = spell_number(pick_value(CNT_MAX), CNT_MAX, cov_p);

		// methylated count placed around the ratio window edges
		mg = tracker.margin;
		lo_m = (mg * cov_p + 65535) >> 16;
		hi_m = ((65536 - mg) * cov_p) >> 16;
		case ($urandom_range(0, 5))
			0:       mv = (lo_m == 0) ? 0 : lo_m - 1;
			1:       mv = lo_m;
			2:       mv = hi_m;
			3:       mv = hi_m + 1;
			4:       mv = {$urandom, $urandom} % (cov_p + 1);
			default: mv = pick_value(CNT_MAX);
		endcase
		meth_txt = spell_number(mv, CNT_MAX, meth_p);

		if (kind < 31) begin
			nf = $urandom_range(1, 5);
		end else begin
			nf = 6;
			if ($urandom_range(0, 3) == 0)
				nf += $urandom_range(1, 3);
		end
		if ($urandom_range(0, 9) == 0)
			line_q.push_back(pick_delim());

		for (f = 1; f <= nf; f++) begin
			if (f > 1) begin
				line_q.push_back(pick_delim());
				if ($urandom_range(0, 7) == 0)
					line_q.push_back(pick_delim());
			end
			case (f)
				1: begin
					// expected name, or one that is short, long or off by a byte
					nl = tracker.name_bytes();
					head = line_q.size();
					if (nl == 0) begin
						line_q.push_back("q");
					end else begin
						for (k = 0; k < nl; k++)
							line_q.push_back(tracker.name_byte(k));
						case ($urandom_range(0, 9))
							7: if (nl > 1)
								void'(line_q.pop_back());
							8: line_q.push_back("_");
							9: begin
								k = head + $urandom_range(0, nl - 1);
								nb = line_q[k] ^ 8'h40;
								if (is_blank(nb))
									nb = "Z";
								line_q[k] = nb;
							end
							default: ;
						endcase
					end
				end
				2:       add_text(pos_txt);
				3:       add_text(strand_txt);
				4:       add_text("CG");
				5:       add_text(meth_txt);
				6:       add_text(cov_txt);
				default: add_text($sformatf("x%0d", $urandom_range(0, 9)));
			endcase
		end
		if ($urandom_range(0, 5) == 0)
			line_q.push_back(pick_delim());
		if (kind < 21 && line_q.size() > 1) begin
			n = $urandom_range(1, line_q.size() - 1);
			while (line_q.size() > n)
				void'(line_q.pop_back());
		end

		// reference mostly on or beside the parsed position
		case ($urandom_range(0, 6))
			0, 1:    rp = POS_W'(pos_p);
			2:       rp = POS_W'(pos_p - 1);
			3:       rp = POS_W'(pos_p + 1);
			4:       rp = POS_MAX;
			5:       rp = '0;
			default: rp = POS_W'($urandom);
		endcase
	endtask

	// Result side: random pop stalls, every taken word is checked
	initial begin
		result_rec_t seen;
		int unsigned gap;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = $urandom_range(0, take_gap_max);
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			seen.status = status_t'(status);
			seen.site_position = site_position;
			seen.strand_code = strand_code;
			seen.meth_count = meth_count;
			seen.cover_count = cover_count;
			tracker.match_outcome(seen);
		end
	end

	// Stimulus
	initial begin
		logic [POS_W-1:0] rp;
		int unsigned      phase, budget;
		bit               paused;
		tracker = new();
		paused = 0;
		arst_n <= 1'b0;
		write_enable <= 1'b0;
		reg_index <= CFG_MIN_METH;
		write_data <= '0;
		push <= 1'b0;
		text_byte <= '0;
		line_end <= 1'b0;
		ref_position <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: the expected name is the single byte zero
		line_q.delete();
		line_q.push_back(8'h00);
		add_text(" 100 + CG 3 5");
		send_line(100);
		say_line("\n", 5);

		// "chr1", ratio window a quarter to three quarters, plus strand only
		wait_for_outcomes();
		set_filters(1, 2, 16'h4000, SM_PLUS, 64'h0000_0000_3172_6863, '0, 4);
		say_line("chr1 50 + CG 1 4", 60);
		say_line("chr1\t70\t+\tCG\t3\t4", 60);
		say_line("chr1 70 - CG 3 4", 70);
		say_line("chr12 70 + CG 3 4", 70);
		say_line("chr 1 70 + CG 3 4", 70);
		say_line("chr1 99999999999 + CG 99999999 99999999\n", POS_MAX);
		say_line("chr1 -5 +x . 0 0", 0);
		say_line("  chr1", 0);
		say_line("chr1 12 + CG 2 4 extra more fields beyond", 12);
		say_line("chr1chr1chr1chr1chr1chr1chr1chr1chr1 1 + CG 2 4", 1);
		say_line("chr1 0012a9 + CG 2 4", 12);

		// Empty expected name, margin above one half, any strand
		wait_for_outcomes();
		set_filters(0, 0, 16'd40000, SM_PASS_ALL, '0, '0, 0);
		say_line(" \t ", 3);
		say_line("a 1 + CG 1 2", 1);

		// Full sixteen byte name, minus strand only
		wait_for_outcomes();
		set_filters(0, 0, 16'h0000, SM_MINUS, 64'h6867_6665_6463_6261,
			64'h706f_6e6d_6c6b_6a69, 16);
		say_line("abcdefghijklmnop 7 - CG 0 1", 8);
		say_line("abcdefghijklmnop 9 + CG 1 1", 9);

		// Random records under a range of filter settings
		for (phase = 0; phase < 6; phase++) begin
			wait_for_outcomes();
			case (phase)
				0: set_filters(0, 0, 16'h0000, SM_ANY, random_name_word(),
					random_name_word(), 16);
				1: set_filters(CNT_MAX, CNT_MAX, 16'hffff, SM_MINUS, '1, '1, 31);
				2: set_filters(0, 1, 16'h8000, SM_PASS_ALL, '0, '0, 0);
				default: set_filters(CNT_W'($urandom_range(0, 4)),
					CNT_W'($urandom_range(0, 4)),
					($urandom_range(0, 3) == 0) ? 16'h0 : MARGIN_W'($urandom_range(0, 32768)),
					2'($urandom_range(0, 3)), random_name_word(), random_name_word(),
					CLEN_W'($urandom_range(1, 16)));
			endcase
			budget = bytes_sent + PHASE_BYTES;
			while (bytes_sent < budget) begin
				if ($urandom_range(0, 7) == 0) begin
					send_gap_max = pick_gap();
					take_gap_max = pick_gap();
				end
				// one hold-off mid-phase until the block has caught up
				if (phase == 3 && !paused && bytes_sent + PHASE_BYTES / 2 >= budget) begin
					wait_for_outcomes();
					paused = 1;
				end
				make_record(rp);
				send_line(rp);
			end
		end

		wait_for_outcomes();
		if (tracker.faults == 0)
			$display("methylation_record_classifier verification clean");
		else
			$display("methylation_record_classifier verification failed");
		$finish;
	end

endmodule
